/* src/csu_pkg.sv */
// Shared types, widths and constants for the context statistics update block.
package csu_pkg;

   localparam int CTX_COUNT_DEF = 365;

   localparam int CTX_W      = 9;
   localparam int ERR_W      = 16;
   localparam int MAG_W      = 32;
   localparam int BIAS_W     = 32;
   localparam int CORR_W     = 8;
   localparam int CNT_W      = 16;
   localparam int SAMPLE_W   = 16;
   localparam int NEAR_W     = 8;
   localparam int THR_W      = 16;
   localparam int STEP_W     = NEAR_W + 1;
   localparam int PROD_W     = ERR_W + STEP_W + 1;
   localparam int SUM_W      = BIAS_W + 1;
   localparam int DIVIDEND_W = SAMPLE_W + 1;

   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SAMPLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 2'd2;

   localparam logic [SAMPLE_W-1:0] MAX_SAMPLE_RESET = 16'd255;
   localparam logic [NEAR_W-1:0]   NEAR_RESET       = 8'd0;
   localparam logic [THR_W-1:0]    THRESHOLD_RESET  = 16'd64;
   localparam logic [MAG_W-1:0]    A0_RESET         = 32'd4;

   // initial magnitude: max(A0_MIN, (range + 32) >> 6), range = quotient + 1
   localparam int A0_ROUND = 33;
   localparam int A0_SHIFT = 6;
   localparam int A0_MIN   = 2;

   localparam logic signed [CORR_W-1:0] CORR_MAX = 8'sh7f;
   localparam logic signed [CORR_W-1:0] CORR_MIN = 8'sh80;

   typedef struct packed {
      logic [SAMPLE_W-1:0] max_sample;
      logic [NEAR_W-1:0]   near;
      logic [THR_W-1:0]    threshold;
   } cfg_type;

   typedef struct packed {
      logic                    opcode;
      logic [CTX_W-1:0]        context_index;
      logic signed [ERR_W-1:0] error_value;
   } req_type;

   typedef struct packed {
      logic [CTX_W-1:0]         context_echo;
      logic [MAG_W-1:0]         magnitude_sum;
      logic signed [BIAS_W-1:0] bias_sum;
      logic signed [CORR_W-1:0] correction;
      logic [CNT_W-1:0]         occurrence_count;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_CLEAR,
      KIND_UPDATE,
      KIND_BAD
   } kind_type;

   typedef struct packed {
      kind_type                 kind;
      logic [CTX_W-1:0]         ctx;
      logic [ERR_W-1:0]         err_abs;
      logic signed [PROD_W-1:0] err_prod;
   } qitem_type;

   typedef struct packed {
      logic [MAG_W-1:0]         mag;
      logic signed [BIAS_W-1:0] bias;
      logic signed [CORR_W-1:0] corr;
      logic [CNT_W-1:0]         count;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_CANCEL,
      ST_BAD,
      ST_DIV,
      ST_CLR_OUT,
      ST_SWEEP
   } back_state_type;

endpackage

/* src/csu_front.sv */
// Front end: accepts requests, classifies them and precomputes error terms.
module csu_front #(
   parameter int REGULAR_CONTEXTS = csu_pkg::CTX_COUNT_DEF
) (
   input  logic               req_valid,
   output logic               req_stall,
   input  csu_pkg::req_type   req_data,
   input  csu_pkg::cfg_type   cfg,
   input  logic               q_full,
   input  logic               sweep_busy,
   output logic               q_push,
   output csu_pkg::qitem_type q_push_data
);
   import csu_pkg::*;

   localparam logic [CTX_W:0] CTX_LIMIT = (CTX_W+1)'(REGULAR_CONTEXTS);

   logic [STEP_W-1:0] step;
   logic              in_range;

   assign step      = {cfg.near, 1'b1};
   assign in_range  = {1'b0, req_data.context_index} < CTX_LIMIT;
   assign req_stall = q_full || sweep_busy;
   assign q_push    = req_valid && !req_stall;

   always_comb begin
      q_push_data.ctx      = req_data.context_index;
      q_push_data.err_prod = req_data.error_value * $signed({1'b0, step});
      q_push_data.err_abs  = req_data.error_value[ERR_W-1] ?
                             (~req_data.error_value + ERR_W'(1)) : req_data.error_value;
      priority if (!req_data.opcode) begin
         q_push_data.kind = KIND_CLEAR;
      end else if (in_range) begin
         q_push_data.kind = KIND_UPDATE;
      end else begin
         q_push_data.kind = KIND_BAD;
      end
   end

endmodule

/* src/csu_queue.sv */
// Short FIFO between the front end and the back end.
module csu_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  csu_pkg::qitem_type push_data,
   input  logic               pop,
   output csu_pkg::qitem_type pop_data,
   output logic               full,
   output logic               empty
);
   import csu_pkg::*;

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);

   qitem_type         slots [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   assign full     = fill_ff == FULL_FILL;
   assign empty    = fill_ff == '0;
   assign pop_data = slots[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("queue pop while empty");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_FILL)
      else $error("queue fill beyond depth");
`endif

endmodule

/* src/csu_div.sv */
// Restoring divider, one quotient bit per cycle, for the initial magnitude.
module csu_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [csu_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [csu_pkg::STEP_W-1:0]        divisor,
   output logic                              done,
   output logic [csu_pkg::DIVIDEND_W-1:0]    quotient
);
   import csu_pkg::*;

   localparam int STEP_CNT_W = $clog2(DIVIDEND_W);
   localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(DIVIDEND_W - 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [STEP_CNT_W-1:0]   step_ff, step_in;
   logic [STEP_W-1:0]       rem_ff, rem_in;
   logic [STEP_W-1:0]       divisor_ff, divisor_in;
   logic [DIVIDEND_W-1:0]   quo_ff, quo_in;
   logic [STEP_W:0]         trial;
   logic [STEP_W:0]         diff;
   logic                    fits;

   assign trial    = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff     = trial - {1'b0, divisor_ff};
   assign fits     = trial >= {1'b0, divisor_ff};
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      busy_in    = busy_ff;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      done_in    = 1'b0;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         step_in = step_ff + STEP_CNT_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

endmodule

/* src/csu_back.sv */
// Back end: context memory, read-modify-write update, clear sweep, result register.
module csu_back #(
   parameter int REGULAR_CONTEXTS = csu_pkg::CTX_COUNT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  csu_pkg::cfg_type   cfg,
   input  logic               q_empty,
   input  csu_pkg::qitem_type q_data,
   output logic               q_pop,
   output logic               sweep_busy,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output csu_pkg::rsp_type   rsp_data
);
   import csu_pkg::*;

   localparam int ADDR_W = (REGULAR_CONTEXTS > 1) ? $clog2(REGULAR_CONTEXTS) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(REGULAR_CONTEXTS - 1);

   back_state_type           state_ff, state_in;
   qitem_type                item_ff, item_in;
   entry_type                rd_ff;
   logic signed [SUM_W-1:0]  acc_bias_ff, acc_bias_in;
   logic [MAG_W-1:0]         acc_mag_ff, acc_mag_in;
   logic [CNT_W:0]           acc_count_ff, acc_count_in;
   logic signed [CORR_W-1:0] acc_corr_ff, acc_corr_in;
   logic [MAG_W-1:0]         a0_ff, a0_in;
   logic [ADDR_W-1:0]        ptr_ff, ptr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   entry_type                ctx_mem [REGULAR_CONTEXTS];
   logic                     mem_we;
   logic [ADDR_W-1:0]        mem_waddr;
   logic [ADDR_W-1:0]        mem_raddr;
   entry_type                mem_wdata;
   entry_type                init_entry;

   logic                     div_start;
   logic                     div_done;
   logic [DIVIDEND_W-1:0]    div_dividend;
   logic [STEP_W-1:0]        div_divisor;
   logic [DIVIDEND_W-1:0]    div_quotient;
   logic [DIVIDEND_W:0]      range_sum;
   logic [DIVIDEND_W:0]      a0_raw;

   logic                     out_free;
   logic                     rsp_load;
   rsp_type                  rsp_new;

   logic signed [SUM_W-1:0]  b_sum;
   logic [MAG_W-1:0]         mag_sum;
   logic                     halve;
   logic signed [SUM_W-1:0]  cnt_ext;
   logic signed [SUM_W-1:0]  neg_n;
   logic signed [SUM_W-1:0]  b_plus;
   logic signed [SUM_W-1:0]  b_minus;
   logic signed [SUM_W-1:0]  fin_bias;
   logic signed [CORR_W-1:0] fin_corr;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign sweep_busy = state_ff == ST_SWEEP;

   assign init_entry.mag   = a0_ff;
   assign init_entry.bias  = '0;
   assign init_entry.corr  = '0;
   assign init_entry.count = CNT_W'(1);

   // initial magnitude from the divider result
   assign div_dividend = DIVIDEND_W'(cfg.max_sample) + DIVIDEND_W'({cfg.near, 1'b0});
   assign div_divisor  = {cfg.near, 1'b1};
   assign range_sum    = {1'b0, div_quotient} + (DIVIDEND_W+1)'(A0_ROUND);
   assign a0_raw       = range_sum >> A0_SHIFT;

   csu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // accumulate and halve; held while the result waits
   always_comb begin
      b_sum = $signed({rd_ff.bias[BIAS_W-1], rd_ff.bias})
            + $signed({{(SUM_W-PROD_W){item_ff.err_prod[PROD_W-1]}}, item_ff.err_prod});
      mag_sum = rd_ff.mag + MAG_W'(item_ff.err_abs);
      halve   = rd_ff.count >= cfg.threshold;
      if (state_ff == ST_ACCUM) begin
         acc_bias_in  = halve ? (b_sum >>> 1) : b_sum;
         acc_mag_in   = halve ? (mag_sum >> 1) : mag_sum;
         acc_count_in = (halve ? {1'b0, rd_ff.count >> 1} : {1'b0, rd_ff.count})
                      + (CNT_W+1)'(1);
         acc_corr_in  = rd_ff.corr;
      end else begin
         acc_bias_in  = acc_bias_ff;
         acc_mag_in   = acc_mag_ff;
         acc_count_in = acc_count_ff;
         acc_corr_in  = acc_corr_ff;
      end
   end

   // bias cancellation
   always_comb begin
      cnt_ext = $signed({{(SUM_W-CNT_W-1){1'b0}}, acc_count_ff});
      neg_n   = -cnt_ext;
      b_plus  = acc_bias_ff + cnt_ext;
      b_minus = acc_bias_ff - cnt_ext;
      priority if (acc_bias_ff <= neg_n) begin
         fin_bias = (b_plus <= neg_n) ? (neg_n + SUM_W'(1)) : b_plus;
         fin_corr = (acc_corr_ff != CORR_MIN) ? (acc_corr_ff - CORR_W'(1)) : acc_corr_ff;
      end else if (!acc_bias_ff[SUM_W-1] && (acc_bias_ff != '0)) begin
         fin_bias = b_minus[SUM_W-1] ? b_minus : '0;
         fin_corr = (acc_corr_ff != CORR_MAX) ? (acc_corr_ff + CORR_W'(1)) : acc_corr_ff;
      end else begin
         fin_bias = acc_bias_ff;
         fin_corr = acc_corr_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               unique case (q_data.kind)
                  KIND_UPDATE: state_in = ST_ACCUM;
                  KIND_CLEAR:  state_in = ST_DIV;
                  default:     state_in = ST_BAD;
               endcase
            end
         end
         ST_ACCUM:   state_in = ST_CANCEL;
         ST_CANCEL:  if (out_free) state_in = ST_IDLE;
         ST_BAD:     if (out_free) state_in = ST_IDLE;
         ST_DIV:     if (div_done) state_in = ST_CLR_OUT;
         ST_CLR_OUT: if (out_free) state_in = ST_SWEEP;
         ST_SWEEP:   if (ptr_ff == LAST_ADDR) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop     = 1'b0;
      div_start = 1'b0;
      mem_raddr = q_data.ctx[ADDR_W-1:0];
      mem_we    = 1'b0;
      mem_waddr = item_ff.ctx[ADDR_W-1:0];
      mem_wdata = init_entry;
      rsp_load  = 1'b0;
      rsp_new   = '0;
      a0_in     = a0_ff;
      ptr_in    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            q_pop     = !q_empty;
            div_start = !q_empty && (q_data.kind == KIND_CLEAR);
         end
         ST_ACCUM: begin
         end
         ST_CANCEL: begin
            if (out_free) begin
               mem_we                   = 1'b1;
               mem_wdata.mag            = acc_mag_ff;
               mem_wdata.bias           = fin_bias[BIAS_W-1:0];
               mem_wdata.corr           = fin_corr;
               mem_wdata.count          = acc_count_ff[CNT_W-1:0];
               rsp_load                 = 1'b1;
               rsp_new.context_echo     = item_ff.ctx;
               rsp_new.magnitude_sum    = acc_mag_ff;
               rsp_new.bias_sum         = fin_bias[BIAS_W-1:0];
               rsp_new.correction       = fin_corr;
               rsp_new.occurrence_count = acc_count_ff[CNT_W-1:0];
            end
         end
         ST_BAD: begin
            if (out_free) begin
               rsp_load             = 1'b1;
               rsp_new.context_echo = item_ff.ctx;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               a0_in = (a0_raw < (DIVIDEND_W+1)'(A0_MIN)) ? MAG_W'(A0_MIN) : MAG_W'(a0_raw);
            end
         end
         ST_CLR_OUT: begin
            if (out_free) begin
               rsp_load                 = 1'b1;
               rsp_new.magnitude_sum    = a0_ff;
               rsp_new.occurrence_count = CNT_W'(1);
            end
         end
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            ptr_in    = (ptr_ff == LAST_ADDR) ? '0 : ptr_ff + ADDR_W'(1);
         end
         default: begin
         end
      endcase
   end

   assign item_in      = q_pop ? q_data : item_ff;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = rsp_load ? rsp_new : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         ptr_ff       <= '0;
         a0_ff        <= A0_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         a0_ff        <= a0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      acc_bias_ff  <= acc_bias_in;
      acc_mag_ff   <= acc_mag_in;
      acc_count_ff <= acc_count_in;
      acc_corr_ff  <= acc_corr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ctx_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= ctx_mem[mem_raddr];
   end

`ifndef ASSERT_OFF
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (mem_wdata.count != '0))
      else $error("context count written as zero");

   a_bias_settled: assert property (@(posedge clock) disable iff (reset)
      (mem_we && (state_ff == ST_CANCEL))
         |-> (mem_wdata.bias[BIAS_W-1] || (mem_wdata.bias == '0)))
      else $error("bias positive after cancellation");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside a clear");
`endif

endmodule

/* src/context_stats_update.sv */
// Top level of the context statistics update block.
//
// req_*: one transfer per request. opcode 1 updates context_index with
//   error_value; opcode 0 clears every context. req_stall holds off requests.
// rsp_*: one transfer per request, in request order, held while rsp_stall.
// csr_*: register writes (max_sample, near_tolerance, reset_threshold);
//   csr_ready is always high. Later updates and clears use the new values.
// Update: the back end steps through memory read, accumulate/halve and
//   cancel/write-back; the result register loads at write-back once it is free.
// Out-of-range context: result with zero statistics and the context echoed.
// Clear: the divider computes the initial magnitude, then the result, then a
//   sweep over every entry of the context memory with req_stall high.
// Reset: control cleared, then the same sweep over the context memory with
//   the reset register values; req_stall is high until it ends.
// A 2-entry queue between front and back end keeps accepting while a result
//   waits on rsp_stall, until it fills.
module context_stats_update #(
   parameter int REGULAR_CONTEXTS = csu_pkg::CTX_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  csu_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output csu_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [csu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [csu_pkg::SAMPLE_W-1:0]    csr_data
);
   import csu_pkg::*;

   logic [SAMPLE_W-1:0] max_sample_ff, max_sample_in;
   logic [NEAR_W-1:0]   near_ff, near_in;
   logic [THR_W-1:0]    threshold_ff, threshold_in;
   cfg_type             cfg;
   logic                csr_write;

   logic                q_push;
   qitem_type           q_push_data;
   logic                q_pop;
   qitem_type           q_pop_data;
   logic                q_full;
   logic                q_empty;
   logic                sweep_busy;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      max_sample_in = max_sample_ff;
      near_in       = near_ff;
      threshold_in  = threshold_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MAX_SAMPLE: max_sample_in = csr_data;
            CSR_NEAR:       near_in       = csr_data[NEAR_W-1:0];
            CSR_THRESHOLD:  threshold_in  = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_sample_ff <= MAX_SAMPLE_RESET;
         near_ff       <= NEAR_RESET;
         threshold_ff  <= THRESHOLD_RESET;
      end else begin
         max_sample_ff <= max_sample_in;
         near_ff       <= near_in;
         threshold_ff  <= threshold_in;
      end
   end

   assign cfg.max_sample = max_sample_ff;
   assign cfg.near       = near_ff;
   assign cfg.threshold  = threshold_ff;

   csu_front #(
      .REGULAR_CONTEXTS (REGULAR_CONTEXTS)
   ) u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .cfg         (cfg),
      .q_full      (q_full),
      .sweep_busy  (sweep_busy),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   csu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   csu_back #(
      .REGULAR_CONTEXTS (REGULAR_CONTEXTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_empty    (q_empty),
      .q_data     (q_pop_data),
      .q_pop      (q_pop),
      .sweep_busy (sweep_busy),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the context statistics update block.
`timescale 1ns / 1ps

module testbench;
   import csu_pkg::*;

   localparam int NCTX             = CTX_COUNT_DEF;
   localparam int CTX_TOP          = (1 << CTX_W) - 1;
   localparam int CYCLE_LIMIT      = 1000000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int CLEAR_TAIL       = 16;

   localparam logic OP_CLEAR  = 1'b0;
   localparam logic OP_UPDATE = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum int {LEAN_UP, LEAN_DOWN, LEAN_NONE} lean_type;

   typedef struct packed {
      logic                 is_write;
      logic [CSR_IDX_W-1:0] reg_index;
      logic [SAMPLE_W-1:0]  reg_value;
      req_type              item;
      logic                 known;
      rsp_type              answer;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [SAMPLE_W-1:0]   csr_data = '0;

   // model copy of the context tables and registers
   logic [MAG_W-1:0]         mag_tbl  [NCTX];
   logic signed [BIAS_W-1:0] bias_tbl [NCTX];
   logic signed [CORR_W-1:0] corr_tbl [NCTX];
   logic [CNT_W-1:0]         cnt_tbl  [NCTX];
   logic [SAMPLE_W-1:0]      max_sample_reg = MAX_SAMPLE_RESET;
   logic [NEAR_W-1:0]        near_reg = NEAR_RESET;
   logic [THR_W-1:0]         thr_reg = THRESHOLD_RESET;

   rsp_type        stats_due[$];
   rsp_type        due_head;
   script_row_type script[$];
   int             mismatch_count = 0;
   int             cycle_count = 0;
   bit             gaps_on = 1'b0;
   bit             long_hold = 1'b0;
   int             steady_items = 0;

   context_stats_update DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic void clear_tables();
      int unsigned step_size, span, a0;
      int i;
      step_size = 2 * near_reg + 1;
      span = (max_sample_reg + 2 * near_reg) / step_size + 1;
      a0 = (span + 32) / 64;
      if (a0 < A0_MIN) a0 = A0_MIN;
      for (i = 0; i < NCTX; i++) begin
         mag_tbl[i]  = MAG_W'(a0);
         bias_tbl[i] = '0;
         corr_tbl[i] = '0;
         cnt_tbl[i]  = CNT_W'(1);
      end
   endfunction

   function automatic rsp_type update_stats(input req_type item);
      rsp_type          r;
      longint           err, b, n, step_size;
      logic [MAG_W-1:0] m;
      int               c;
      int unsigned      q;
      r = '0;
      q = item.context_index;
      if (item.opcode == OP_CLEAR) begin
         clear_tables();
         q = 0;
      end else if (q >= NCTX) begin
         r.context_echo = item.context_index;
         return r;
      end else begin
         err = item.error_value;
         step_size = 2 * near_reg + 1;
         b = longint'(bias_tbl[q]) + err * step_size;
         m = mag_tbl[q] + MAG_W'(err < 0 ? -err : err);
         n = longint'(cnt_tbl[q]);
         if (n >= longint'(thr_reg)) begin
            m = m >> 1;
            if (b >= 0) b = b / 2;
            else b = -((1 - b) / 2);
            n = n / 2;
         end
         n = n + 1;
         c = corr_tbl[q];
         if (b <= -n) begin
            b = b + n;
            if (c > int'(CORR_MIN)) c = c - 1;
            if (b <= -n) b = -n + 1;
         end else if (b > 0) begin
            b = b - n;
            if (c < int'(CORR_MAX)) c = c + 1;
            if (b > 0) b = 0;
         end
         mag_tbl[q]  = m;
         bias_tbl[q] = BIAS_W'(b);
         corr_tbl[q] = CORR_W'(c);
         cnt_tbl[q]  = CNT_W'(n);
      end
      r.context_echo     = CTX_W'(q);
      r.magnitude_sum    = mag_tbl[q];
      r.bias_sum         = bias_tbl[q];
      r.correction       = corr_tbl[q];
      r.occurrence_count = cnt_tbl[q];
      return r;
   endfunction

   function automatic void add_write(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [SAMPLE_W-1:0] value);
      script_row_type row;
      row = '0;
      row.is_write  = 1'b1;
      row.reg_index = idx;
      row.reg_value = value;
      script.push_back(row);
   endfunction

   function automatic void add_item(input logic op, input int ctx, input int err,
                                    input logic known, input rsp_type answer);
      script_row_type row;
      row = '0;
      row.item.opcode        = op;
      row.item.context_index = CTX_W'(ctx);
      row.item.error_value   = ERR_W'(err);
      row.known              = known;
      row.answer             = answer;
      script.push_back(row);
   endfunction

   function automatic logic signed [ERR_W-1:0] pick_error(input lean_type lean);
      int unsigned size;
      int          value;
      case ($urandom_range(0, 3))
         0: size = $urandom_range(4, 15);
         1: size = $urandom_range(16, 255);
         2: size = $urandom_range(256, 4095);
         default: size = $urandom_range(4096, 32767);
      endcase
      case (lean)
         LEAN_UP: value = int'(size);
         LEAN_DOWN: value = ($urandom_range(0, 15) == 0) ? -32768 : -int'(size);
         default: begin
            case ($urandom_range(0, 3))
               0: value = int'($urandom);
               1: value = int'($urandom_range(0, 6)) - 3;
               2: value = -int'(size);
               default: value = int'(size);
            endcase
         end
      endcase
      return value[ERR_W-1:0];
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [SAMPLE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_MAX_SAMPLE: max_sample_reg = value;
         CSR_NEAR:       near_reg = value[NEAR_W-1:0];
         CSR_THRESHOLD:  thr_reg = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_item(input req_type item, input logic known, input rsp_type answer);
      rsp_type predicted;
      if (gaps_on && steady_items == 0 && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      if (steady_items > 0) steady_items--;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = update_stats(item);
      stats_due.push_back(known ? answer : predicted);
   endtask

   // wait out pending results and the sweep that follows a clear
   task automatic settle();
      req_valid <= 1'b0;
      while (stats_due.size() != 0) @(posedge clock);
      repeat (CLEAR_TAIL) @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic shuffle_config(input int unsigned thr_lo, input int unsigned thr_hi);
      write_reg(CSR_MAX_SAMPLE, SAMPLE_W'($urandom_range(1, 65535)));
      write_reg(CSR_NEAR, SAMPLE_W'($urandom));
      write_reg(CSR_THRESHOLD, THR_W'($urandom_range(thr_lo, thr_hi)));
   endtask

   task automatic run_phase(input int count, input lean_type lean, input bit squeeze);
      logic [CTX_W-1:0] hot [3];
      req_type          item;
      int unsigned      pick, clear_pct, bad_pct;
      int               k;
      for (k = 0; k < 3; k++) begin
         case ($urandom_range(0, 3))
            0: hot[k] = '0;
            1: hot[k] = CTX_W'(NCTX - 1);
            default: hot[k] = CTX_W'($urandom_range(0, NCTX - 1));
         endcase
      end
      clear_pct = (lean == LEAN_NONE) ? 4 : 0;
      bad_pct   = (lean == LEAN_NONE) ? 8 : 3;
      if (squeeze) begin
         long_hold = 1'b1;
         steady_items = 40;
      end
      if (lean != LEAN_NONE) begin
         item.opcode        = OP_CLEAR;
         item.context_index = CTX_W'($urandom);
         item.error_value   = ERR_W'($urandom);
         send_item(item, 1'b0, '0);
      end
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         item.opcode      = OP_UPDATE;
         item.error_value = pick_error(lean);
         if (pick < clear_pct) begin
            item.opcode        = OP_CLEAR;
            item.context_index = CTX_W'($urandom);
         end else if (pick < clear_pct + bad_pct) begin
            item.context_index = CTX_W'($urandom_range(NCTX, CTX_TOP));
         end else if (lean != LEAN_NONE || pick < 70) begin
            item.context_index = hot[(lean == LEAN_NONE) ? $urandom_range(0, 2) : 0];
         end else begin
            item.context_index = CTX_W'($urandom_range(0, NCTX - 1));
         end
         send_item(item, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (stats_due.size() == 0) begin
            if (mismatch_count < 10)
               $display("transfer with nothing expected: ctx %0d", rsp_data.context_echo);
            mismatch_count++;
         end else begin
            due_head = stats_due.pop_front();
            if (rsp_data.context_echo !== due_head.context_echo ||
                rsp_data.magnitude_sum !== due_head.magnitude_sum ||
                rsp_data.bias_sum !== due_head.bias_sum ||
                rsp_data.correction !== due_head.correction ||
                rsp_data.occurrence_count !== due_head.occurrence_count) begin
               if (mismatch_count < 10)
                  $display("mismatch: ctx %0d/%0d mag %0d/%0d bias %0d/%0d corr %0d/%0d cnt %0d/%0d (got/exp)",
                           rsp_data.context_echo, due_head.context_echo,
                           rsp_data.magnitude_sum, due_head.magnitude_sum,
                           rsp_data.bias_sum, due_head.bias_sum,
                           rsp_data.correction, due_head.correction,
                           rsp_data.occurrence_count, due_head.occurrence_count);
               mismatch_count++;
            end
         end
      end
   end

   // result side: random stall bursts plus one long hold-off on request
   initial begin
      @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (gaps_on && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   initial begin
      int i;
      clear_tables();

      add_item(OP_UPDATE, 0, 0, 1'b1, {9'd0, 32'd4, 32'sd0, 8'sd0, 16'd2});
      add_item(OP_UPDATE, 364, 32767, 1'b1, {9'd364, 32'd32771, 32'sd0, 8'sd1, 16'd2});
      add_item(OP_UPDATE, 363, -32768, 1'b1, {9'd363, 32'd32772, -32'sd1, -8'sd1, 16'd2});
      add_item(OP_UPDATE, 365, 5, 1'b1, {9'd365, 32'd0, 32'sd0, 8'sd0, 16'd0});
      add_item(OP_UPDATE, 511, -1, 1'b1, {9'd511, 32'd0, 32'sd0, 8'sd0, 16'd0});
      add_item(OP_CLEAR, 364, 77, 1'b1, {9'd0, 32'd4, 32'sd0, 8'sd0, 16'd1});
      add_item(OP_UPDATE, 364, 1, 1'b0, '0);
      for (i = 0; i < 4; i++) add_item(OP_UPDATE, 10, -3, 1'b0, '0);
      // count is now above the new threshold; odd negative bias halves down
      add_write(CSR_THRESHOLD, 16'd4);
      add_item(OP_UPDATE, 10, -2, 1'b0, '0);
      add_write(CSR_NEAR, 16'hff01);
      add_item(OP_UPDATE, 10, 5, 1'b0, '0);
      add_item(OP_CLEAR, 0, 0, 1'b1, {9'd0, 32'd2, 32'sd0, 8'sd0, 16'd1});
      add_write(CSR_MAX_SAMPLE, 16'hffff);
      add_write(CSR_NEAR, 16'h5a00);
      add_write(CSR_SPARE, 16'hffff);
      add_item(OP_CLEAR, 511, -1, 1'b1, {9'd0, 32'd1024, 32'sd0, 8'sd0, 16'd1});
      add_write(CSR_THRESHOLD, 16'hffff);
      add_item(OP_UPDATE, 0, -32768, 1'b0, '0);
      add_item(OP_UPDATE, 364, 32767, 1'b0, '0);
      add_write(CSR_MAX_SAMPLE, 16'd1);
      add_item(OP_CLEAR, 0, 0, 1'b1, {9'd0, 32'd2, 32'sd0, 8'sd0, 16'd1});
      add_item(OP_UPDATE, 200, 12345, 1'b0, '0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      gaps_on = 1'b1;

      for (i = 0; i < script.size(); i++) begin
         if (script[i].is_write) begin
            settle();
            write_reg(script[i].reg_index, script[i].reg_value);
         end else begin
            send_item(script[i].item, script[i].known, script[i].answer);
         end
      end

      // correction driven up to its ceiling
      settle();
      write_reg(CSR_MAX_SAMPLE, 16'hffff);
      write_reg(CSR_NEAR, {SAMPLE_W'($urandom_range(0, 255)) << NEAR_W} | 16'h00ff);
      write_reg(CSR_THRESHOLD, THR_W'($urandom_range(5, 80)));
      run_phase(150, LEAN_UP, 1'b0);

      // correction driven down to its floor
      settle();
      write_reg(CSR_MAX_SAMPLE, 16'd1);
      write_reg(CSR_NEAR, 16'd0);
      write_reg(CSR_THRESHOLD, 16'd4);
      run_phase(150, LEAN_DOWN, 1'b0);

      settle();
      shuffle_config(4, 200);
      run_phase(70, LEAN_NONE, 1'b1);

      settle();
      shuffle_config(4, 65535);
      run_phase(70, LEAN_NONE, 1'b0);

      settle();
      gaps_on = 1'b0;
      shuffle_config(4, 40);
      run_phase(70, LEAN_NONE, 1'b0);

      settle();
      if (mismatch_count == 0 && stats_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* sim.f */
src/csu_pkg.sv
src/csu_front.sv
src/csu_queue.sv
src/csu_div.sv
src/csu_back.sv
src/context_stats_update.sv
verif/testbench.sv
